>>> rtl/core/response_frame_parser_top_macros.svh
// Assertion macros for the response frame parser.
`ifndef RESPONSE_FRAME_PARSER_TOP_MACROS_SVH
`define RESPONSE_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RFP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rfp assertion failed");
`define RFP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rfp reset assertion failed");
`else
`define RFP_ASSERT(label, prop)
`define RFP_ASSERT_RST(label, prop)
`endif

`endif

>>> rtl/core/rfp_pkg.sv
// Shared types and constants for the response frame parser.
`default_nettype none
package rfp_pkg;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  localparam logic [1:0] REG_LAST_CMD  = 2'd0;
  localparam logic [1:0] REG_BUF_SPACE = 2'd1;
  localparam logic [1:0] REG_REPLY_ID  = 2'd2;
  localparam logic [1:0] REG_HUNT_LIM  = 2'd3;

  localparam logic [7:0]  START_BYTE   = 8'hFF;
  localparam logic [15:0] DEFAULT_HUNT = 16'd1000;

  localparam int OUT_DATA_W = 24;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HUNT, PH_LEN, PH_LCS, PH_XHI, PH_XLO,
    PH_XCS, PH_TFI, PH_CMD, PH_DATA, PH_DCS, PH_POST
  } phase_t;

  typedef struct packed {
    logic [7:0]  last_command;
    logic [7:0]  buffer_space;
    logic [7:0]  reply_identifier;
    logic [15:0] hunt_limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] payload_length;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/rfp_cfg.sv
// Configuration register bank.
`default_nettype none
module rfp_cfg
  import rfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_command     <= 8'd0;
      cfg.buffer_space     <= 8'd255;
      cfg.reply_identifier <= 8'd213;
      cfg.hunt_limit       <= DEFAULT_HUNT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAST_CMD:  cfg.last_command     <= cfg_data[7:0];
        REG_BUF_SPACE: cfg.buffer_space     <= cfg_data[7:0];
        REG_REPLY_ID:  cfg.reply_identifier <= cfg_data[7:0];
        REG_HUNT_LIM:  cfg.hunt_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rfp_engine.sv
// Frame state machine: per-beat checks and next-state logic.
`default_nettype none
module rfp_engine
  import rfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output result_t         res
);

  phase_t      phase, phase_next;
  logic [15:0] hunt_budget, hunt_budget_next;
  logic [7:0]  first_length_byte, first_length_byte_next;
  logic [15:0] frame_length, frame_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  bytes_received, bytes_received_next;

  logic [15:0] len_full;
  logic [7:0]  len_sum;
  logic        len_bad;
  logic [15:0] pay_len;
  logic        no_space;
  logic        ext_len;
  logic        cmd_ok;
  logic [7:0]  sum_next;
  logic [7:0]  cnt_inc;
  logic        active;

  assign len_full = (phase == PH_LCS) ? {8'd0, first_length_byte} : frame_length;
  assign len_sum  = len_full[15:8] + len_full[7:0] + rx_byte;
  assign len_bad  = (len_full < 16'd2) || (len_sum != 8'd0);
  assign pay_len  = len_full - 16'd2;
  assign no_space = pay_len > {8'd0, cfg.buffer_space};
  assign ext_len  = (first_length_byte == 8'hFF) && (rx_byte == 8'hFF);
  assign cmd_ok   = {1'b0, rx_byte} == ({1'b0, cfg.last_command} + 9'd1);
  assign sum_next = running_sum + rx_byte;
  assign cnt_inc  = bytes_received + 8'd1;
  assign active   = fire && (opcode != OP_START) && (opcode == OP_BYTE || opcode == OP_TIMEOUT)
                    && (phase != PH_IDLE);

  // result of the current beat
  always_comb begin
    res = '0;
    res.status = ST_OK;
    if (active) begin
      if (phase == PH_HUNT) begin
        if (opcode == OP_BYTE && rx_byte != 8'd0) begin
          if (rx_byte != START_BYTE) begin
            res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_INVALID;
          end
        end else if (hunt_budget == 16'd0) begin
          res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1;
          res.status = (opcode == OP_TIMEOUT) ? ST_TIMEOUT : ST_INVALID;
        end
      end else if (opcode == OP_TIMEOUT) begin
        res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_TIMEOUT;
      end else begin
        unique case (phase)
          PH_LCS, PH_XCS: begin
            if (!(phase == PH_LCS && ext_len)) begin
              if (len_bad) begin
                res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_INVALID;
              end else if (no_space) begin
                res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_NOSPACE;
              end
            end
          end
          PH_TFI: begin
            if (rx_byte != cfg.reply_identifier) begin
              res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_INVALID;
            end
          end
          PH_CMD: begin
            if (!cmd_ok) begin
              res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_INVALID;
            end
          end
          PH_DATA: begin
            res.valid = 1'b1;
            res.data_byte = rx_byte;
          end
          PH_DCS: begin
            if (sum_next != 8'd0) begin
              res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1; res.status = ST_INVALID;
            end
          end
          PH_POST: begin
            res.valid = 1'b1; res.kind = 1'b1; res.last = 1'b1;
            if (rx_byte != 8'd0) begin
              res.status = ST_INVALID;
            end else begin
              res.status = ST_OK;
              res.payload_length = frame_length[7:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    phase_next             = phase;
    hunt_budget_next       = hunt_budget;
    first_length_byte_next = first_length_byte;
    frame_length_next      = frame_length;
    running_sum_next       = running_sum;
    bytes_received_next    = bytes_received;
    if (fire && opcode == OP_START) begin
      hunt_budget_next = (cfg.hunt_limit != 16'd0) ? cfg.hunt_limit : DEFAULT_HUNT;
      phase_next       = PH_HUNT;
    end else if (active) begin
      if (phase == PH_HUNT) begin
        if (opcode == OP_BYTE && rx_byte != 8'd0) begin
          phase_next = PH_LEN;
        end else if (hunt_budget != 16'd0) begin
          hunt_budget_next = hunt_budget - 16'd1;
        end
      end else if (opcode == OP_BYTE) begin
        unique case (phase)
          PH_LEN: begin
            first_length_byte_next = rx_byte;
            phase_next = PH_LCS;
          end
          PH_LCS, PH_XCS: begin
            if (phase == PH_LCS && ext_len) begin
              phase_next = PH_XHI;
            end else begin
              frame_length_next = pay_len;
              phase_next = PH_TFI;
            end
          end
          PH_XHI: begin
            frame_length_next = {rx_byte, 8'd0};
            phase_next = PH_XLO;
          end
          PH_XLO: begin
            frame_length_next = {frame_length[15:8], rx_byte};
            phase_next = PH_XCS;
          end
          PH_TFI: begin
            running_sum_next = rx_byte;
            phase_next = PH_CMD;
          end
          PH_CMD: begin
            running_sum_next    = sum_next;
            bytes_received_next = 8'd0;
            phase_next = (frame_length != 16'd0) ? PH_DATA : PH_DCS;
          end
          PH_DATA: begin
            running_sum_next    = sum_next;
            bytes_received_next = cnt_inc;
            if ({8'd0, cnt_inc} >= frame_length) begin
              phase_next = PH_DCS;
            end
          end
          PH_DCS: begin
            running_sum_next = sum_next;
            phase_next = PH_POST;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      if (res.last) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      hunt_budget       <= 16'd0;
      first_length_byte <= 8'd0;
      frame_length      <= 16'd0;
      running_sum       <= 8'd0;
      bytes_received    <= 8'd0;
    end else begin
      phase             <= phase_next;
      hunt_budget       <= hunt_budget_next;
      first_length_byte <= first_length_byte_next;
      frame_length      <= frame_length_next;
      running_sum       <= running_sum_next;
      bytes_received    <= bytes_received_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rfp_out_reg.sv
// Result register on the master side.
`default_nettype none
module rfp_out_reg
  import rfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire result_t               res,
  output logic                       ready,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast
);

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      m_tdata <= {6'd0, res.payload_length, res.status, res.data_byte};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/response_frame_parser_top.sv
// Top level of the response frame parser.
//
//   channel | signals                          | beat
//   s       | s_tvalid s_tready s_tdata s_tuser | one event: start, byte or timeout
//   m       | m_tvalid m_tready m_tdata m_tuser | payload byte or final status
//           | m_tlast                           |
//   cfg     | cfg_valid cfg_ready cfg_index     | one register write
//           | cfg_data                          |
//
// One input beat per cycle while s_tready is high; its result, if any, is on m
// in the next cycle. The result register holds one beat; s_tready drops only
// while it is full and m_tready is low. Reset is synchronous; the registers
// return to their defaults and the parser goes idle.
`default_nettype none
`include "response_frame_parser_top_macros.svh"
module response_frame_parser_top
  import rfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]            s_tuser,   // [1:0] opcode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [7:0] data_byte, [9:8] status,
                                                // [17:10] payload_length, rest zero
  output logic                       m_tuser,   // [0] kind
  output logic                       m_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  cfg_t    cfg;
  result_t res;
  logic    fire;

  assign cfg_ready = 1'b1;
  assign fire      = s_tvalid && s_tready;

  rfp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .opcode  (s_tuser),
    .rx_byte (s_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  rfp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .res      (res),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `RFP_ASSERT(a_last_is_status, m_tvalid |-> (m_tlast == m_tuser))
  `RFP_ASSERT(a_data_no_status, (m_tvalid && !m_tuser) |-> (m_tdata[17:8] == 10'd0))
  `RFP_ASSERT(a_len_only_ok, (m_tvalid && m_tuser && m_tdata[9:8] != ST_OK) |-> (m_tdata[17:10] == 8'd0))
  `RFP_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready)
  `RFP_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid)

endmodule
`default_nettype wire
